// File: hdl/brd_pkg.sv
package brd_pkg;

   localparam int HISTORY_DEPTH = 4;
   localparam int SLOT_W        = $clog2(HISTORY_DEPTH);
   localparam int BTN_W         = 8;
   localparam int TIMEOUT_W     = 8;
   localparam int CSR_ADDR_W    = 3;
   localparam int CSR_DATA_W    = 32;
   localparam int REQ_DATA_W    = 16;
   localparam int RSP_DATA_W    = 24;

   localparam logic [BTN_W-1:0]     DEBOUNCED_RESET = 8'hFF;
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_STEP    = TIMEOUT_W'(HISTORY_DEPTH);
   localparam logic [SLOT_W-1:0]    LAST_SLOT       = SLOT_W'(HISTORY_DEPTH - 1);

   localparam logic KIND_TICK = 1'b0;
   localparam logic KIND_EDGE = 1'b1;

   // Register index as seen on the word address of the configuration port.
   localparam logic [CSR_ADDR_W-3:0] REG_BUTTON_MASK = '0;

   typedef struct packed {
      logic             clear;
      logic [BTN_W-1:0] mask;
   } cfg_type;

   typedef struct packed {
      logic             sampling_active;
      logic [BTN_W-1:0] edge_enable;
      logic             release_event;
      logic [BTN_W-1:0] released_buttons;
   } result_type;

endpackage

// File: hdl/brd_csr.sv
module brd_csr
   import brd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   logic [BTN_W-1:0] mask_ff;
   logic [BTN_W-1:0] mask_in;
   logic             hit_mask;
   logic             load;

   assign csr_pready = 1'b1;
   assign hit_mask   = (csr_paddr[CSR_ADDR_W-1:2] == REG_BUTTON_MASK);

   // A write of zero leaves the mask and everything else as it was.
   assign load = csr_psel && csr_penable && csr_pwrite && csr_pready && hit_mask
                 && (csr_pwdata[BTN_W-1:0] != '0);

   always_comb begin
      mask_in = mask_ff;
      if (load) begin
         mask_in = csr_pwdata[BTN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else begin
         mask_ff <= mask_in;
      end
   end

   assign csr_prdata = hit_mask ? {{(CSR_DATA_W-BTN_W){1'b0}}, mask_ff} : '0;
   assign cfg.clear  = load;
   assign cfg.mask   = mask_ff;

endmodule

// File: hdl/brd_core.sv
module brd_core
   import brd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  cfg_type          cfg,
   input  logic             accept,
   input  logic             kind,
   input  logic [BTN_W-1:0] port_sample,
   input  logic [BTN_W-1:0] edge_pins,
   output result_type       result
);

   logic [BTN_W-1:0]     history_ff [HISTORY_DEPTH];
   logic [BTN_W-1:0]     history_in [HISTORY_DEPTH];
   logic [SLOT_W-1:0]    slot_ff;
   logic [SLOT_W-1:0]    slot_in;
   logic [BTN_W-1:0]     last_deb_ff;
   logic [BTN_W-1:0]     last_deb_in;
   logic [BTN_W-1:0]     awaiting_ff;
   logic [BTN_W-1:0]     awaiting_in;
   logic [TIMEOUT_W-1:0] timeout_ff;
   logic [TIMEOUT_W-1:0] timeout_in;
   logic                 sampling_ff;
   logic                 sampling_in;
   logic [BTN_W-1:0]     disabled_ff;
   logic [BTN_W-1:0]     disabled_in;

   logic [BTN_W-1:0] hit;
   logic [BTN_W-1:0] deb;
   logic [BTN_W-1:0] changed;
   logic [BTN_W-1:0] rise;
   logic [BTN_W-1:0] fall;
   logic [BTN_W-1:0] released;

   always_comb begin
      history_in  = history_ff;
      slot_in     = slot_ff;
      last_deb_in = last_deb_ff;
      awaiting_in = awaiting_ff;
      timeout_in  = timeout_ff;
      sampling_in = sampling_ff;
      disabled_in = disabled_ff;
      released    = '0;
      hit         = edge_pins & cfg.mask & ~disabled_ff;
      deb         = DEBOUNCED_RESET;
      changed     = '0;
      rise        = '0;
      fall        = '0;

      if (accept) begin
         if (kind == KIND_EDGE) begin
            if (hit != '0) begin
               disabled_in = disabled_ff | hit;
               timeout_in  = timeout_ff + TIMEOUT_STEP;
               sampling_in = 1'b1;
            end
         end else if (sampling_ff) begin
            history_in[slot_ff] = port_sample;
            slot_in = (slot_ff == LAST_SLOT) ? '0 : slot_ff + 1'b1;
            for (int i = 0; i < HISTORY_DEPTH; i++) begin
               deb = deb & history_in[i];
            end
            changed = deb ^ last_deb_ff;
            rise    = cfg.mask & changed & deb;
            fall    = cfg.mask & changed & ~deb;
            if (changed != '0) begin
               awaiting_in = (awaiting_ff & ~rise) | fall;
               disabled_in = disabled_ff & ~rise;
               released    = rise;
            end else if (awaiting_ff == '0) begin
               // A decrement from zero wraps and keeps sampling running.
               timeout_in = timeout_ff - 1'b1;
               if (timeout_in == '0) begin
                  sampling_in = 1'b0;
                  disabled_in = '0;
               end
            end
            last_deb_in = deb;
         end
      end

      if (cfg.clear) begin
         for (int i = 0; i < HISTORY_DEPTH; i++) begin
            history_in[i] = '0;
         end
         disabled_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < HISTORY_DEPTH; i++) begin
            history_ff[i] <= '0;
         end
         slot_ff     <= '0;
         last_deb_ff <= DEBOUNCED_RESET;
         awaiting_ff <= '0;
         timeout_ff  <= '0;
         sampling_ff <= 1'b0;
         disabled_ff <= '0;
      end else begin
         history_ff  <= history_in;
         slot_ff     <= slot_in;
         last_deb_ff <= last_deb_in;
         awaiting_ff <= awaiting_in;
         timeout_ff  <= timeout_in;
         sampling_ff <= sampling_in;
         disabled_ff <= disabled_in;
      end
   end

   assign result.released_buttons = released;
   assign result.release_event    = (released != '0);
   assign result.edge_enable      = cfg.mask & ~disabled_in;
   assign result.sampling_active  = sampling_in;

endmodule

// File: hdl/button_release_debouncer.sv
// Debouncer for an 8-bit port of active-low buttons. Each request is either a
// sampling tick carrying the port levels or a falling-edge event carrying the
// pins that saw an edge (req_tuser high). Every request produces exactly one
// response; it appears on the response channel in the cycle after the request
// is taken. A new request can be taken in every cycle while no response waits
// or the waiting response is read, since the state update and the response
// are computed in one registered pass and the response register frees as it
// is read. The button mask is written through the register port at address
// 0; a write of zero is ignored, and a non-zero write clears the sample
// history and enables edge detection on every button again. Write it only
// while no request is in flight.
module button_release_debouncer
   import brd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // port_sample[7:0], edge_pins[15:8]
   input  logic                  req_tuser,  // kind
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // released_buttons[7:0], release_event[8], edge_enable[16:9],
   // sampling_active[17], zero[23:18]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type    cfg;
   result_type result;
   result_type rsp_ff;
   result_type rsp_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       accept;

   brd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   brd_core u_core (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .accept      (accept),
      .kind        (req_tuser),
      .port_sample (req_tdata[BTN_W-1:0]),
      .edge_pins   (req_tdata[2*BTN_W-1:BTN_W]),
      .result      (result)
   );

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_in       = result;
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - $bits(result_type)){1'b0}}, rsp_ff};

endmodule

// File: bench/button_release_debouncer_test.sv
module button_release_debouncer_test;
   import brd_pkg::*;

   localparam int REQUEST_TARGET = 650;
   localparam logic [CSR_ADDR_W-3:0] REG_SPARE  = 1'b1;
   localparam logic [CSR_ADDR_W-1:0] MASK_ADDR  = {REG_BUTTON_MASK, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] SPARE_ADDR = {REG_SPARE, 2'b00};

   typedef struct {
      logic             kind;
      logic [BTN_W-1:0] sample;
      logic [BTN_W-1:0] pins;
   } button_request_type;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata   = '0;  // port_sample[7:0], edge_pins[15:8]
   logic                  req_tuser   = KIND_TICK;  // kind
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   // released_buttons[7:0], release_event[8], edge_enable[16:9],
   // sampling_active[17], zero[23:18]
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   button_request_type pending_requests[$];
   button_request_type offered;
   result_type      expected_reports[$];
   int              error_count     = 0;
   int              requests_queued = 0;
   bit              idling_on       = 1'b1;
   bit              req_taken       = 1'b0;
   int              req_gap_left    = 0;
   int              rsp_stall_left  = 0;
   int              rsp_hold_left   = 0;

   // Predicted state of the debouncer.
   logic [BTN_W-1:0]     btn_mask = '0;
   logic [BTN_W-1:0]     history[HISTORY_DEPTH] = '{default: '0};
   int                   write_slot = 0;
   logic [BTN_W-1:0]     debounced = DEBOUNCED_RESET;
   logic [BTN_W-1:0]     awaiting = '0;
   logic [TIMEOUT_W-1:0] timeout_count = '0;
   logic                 sampling = 1'b0;
   logic [BTN_W-1:0]     edge_off = '0;

   button_release_debouncer dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   task automatic debounce_step(input button_request_type rq);
      logic [BTN_W-1:0] deb, changed, rise, fall, hit;
      result_type rpt;
      deb = '1;
      rise = '0;
      if (rq.kind == KIND_EDGE) begin
         hit = rq.pins & btn_mask & ~edge_off;
         if (hit != '0) begin
            edge_off |= hit;
            timeout_count += TIMEOUT_STEP;
            sampling = 1'b1;
         end
      end else if (sampling) begin
         history[write_slot] = rq.sample;
         write_slot = (write_slot + 1) % HISTORY_DEPTH;
         foreach (history[i]) deb &= history[i];
         changed = deb ^ debounced;
         if (changed != '0) begin
            rise = btn_mask & changed & deb;
            fall = btn_mask & changed & ~deb;
            awaiting = (awaiting & ~rise) | fall;
            edge_off &= ~rise;
         end else if (awaiting == '0) begin
            // The timeout wraps from zero to its top value without stopping.
            timeout_count -= 1'b1;
            if (timeout_count == '0) begin
               sampling = 1'b0;
               edge_off = '0;
            end
         end
         debounced = deb;
      end
      rpt.released_buttons = rise;
      rpt.release_event = (rise != '0);
      rpt.edge_enable = btn_mask & ~edge_off;
      rpt.sampling_active = sampling;
      expected_reports.push_back(rpt);
   endtask

   task automatic push_request(input logic kind, input logic [BTN_W-1:0] value);
      button_request_type rq;
      rq.kind = kind;
      rq.sample = (kind == KIND_TICK) ? value : BTN_W'($urandom);
      rq.pins = (kind == KIND_EDGE) ? value : BTN_W'($urandom);
      pending_requests.push_back(rq);
      requests_queued++;
   endtask

   // A press: edge event, contact bounce, held low, bounce again, then released.
   task automatic queue_press(input logic [BTN_W-1:0] mask);
      logic [BTN_W-1:0] pins;
      pins = mask & BTN_W'($urandom);
      if (pins == '0) pins = mask;
      if ($urandom_range(0, 3) == 0) pins |= BTN_W'($urandom);
      push_request(KIND_EDGE, pins);
      repeat ($urandom_range(0, 4)) push_request(KIND_TICK, ~(pins & BTN_W'($urandom)));
      repeat ($urandom_range(1, 5)) push_request(KIND_TICK, ~pins ^ (~mask & BTN_W'($urandom)));
      repeat ($urandom_range(0, 4)) push_request(KIND_TICK, ~(pins & BTN_W'($urandom)));
      repeat (HISTORY_DEPTH + $urandom_range(0, 2)) push_request(KIND_TICK, '1);
      repeat (($urandom_range(0, 5) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8))
         push_request(KIND_TICK, '1);
   endtask

   task automatic write_register(input logic [CSR_ADDR_W-1:0] addr,
                                 input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (addr[CSR_ADDR_W-1:2] == REG_BUTTON_MASK && value[BTN_W-1:0] != '0) begin
         btn_mask = value[BTN_W-1:0];
         history = '{default: '0};
         edge_off = '0;
      end
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic settle();
      int guard;
      guard = 0;
      do begin
         @(posedge clock);
         guard++;
      end while ((pending_requests.size() != 0 || req_tvalid || expected_reports.size() != 0)
                 && guard < 20000);
      repeat (4) @(posedge clock);
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      req_taken = req_tvalid && req_tready;
      if (req_taken) debounce_step(offered);
   end

   always @(negedge clock) begin
      if (!reset && (!req_tvalid || req_taken)) begin
         if (req_gap_left > 0) begin
            req_gap_left--;
            req_tvalid <= 1'b0;
         end else if (pending_requests.size() != 0) begin
            offered = pending_requests.pop_front();
            req_tvalid <= 1'b1;
            req_tuser <= offered.kind;
            req_tdata <= {offered.pins, offered.sample};
            if (idling_on && $urandom_range(0, 11) == 0) req_gap_left = $urandom_range(1, 19);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (rsp_hold_left > 0) begin
         rsp_hold_left--;
         rsp_tready <= 1'b0;
      end else if (rsp_stall_left > 0) begin
         rsp_stall_left--;
         rsp_tready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 15) == 0) begin
         rsp_stall_left = $urandom_range(1, 19) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      result_type want, got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_reports.size() == 0) begin
            $display("%0t: unexpected report, expected none, actual %h", $time, rsp_tdata);
            error_count++;
         end else begin
            want = expected_reports.pop_front();
            got = rsp_tdata[$bits(result_type)-1:0];
            check_field("released_buttons", want.released_buttons, got.released_buttons);
            check_field("release_event", want.release_event, got.release_event);
            check_field("edge_enable", want.edge_enable, got.edge_enable);
            check_field("sampling_active", want.sampling_active, got.sampling_active);
            check_field("padding", 0, rsp_tdata[RSP_DATA_W-1:$bits(result_type)]);
         end
      end
   end

   initial begin
      logic [BTN_W-1:0] mask;
      int phase;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // With no mask set there are no buttons, so neither request may act.
      push_request(KIND_EDGE, 8'hFF);
      push_request(KIND_TICK, 8'h00);
      settle();
      write_register(MASK_ADDR, '0);
      write_register(SPARE_ADDR, 32'h55);
      write_register(MASK_ADDR, 32'h0F);

      // Non-button pins, a first edge, a repeat on a disabled pin, an edge while
      // sampling, then press and release patterns until the timeout runs out.
      push_request(KIND_EDGE, 8'hF0);
      push_request(KIND_EDGE, 8'h01);
      push_request(KIND_EDGE, 8'h01);
      push_request(KIND_EDGE, 8'h02);
      push_request(KIND_TICK, 8'hFF);
      push_request(KIND_TICK, 8'hFE);
      push_request(KIND_TICK, 8'hFF);
      push_request(KIND_TICK, 8'hFF);
      push_request(KIND_TICK, 8'hFF);
      push_request(KIND_TICK, 8'h00);
      push_request(KIND_TICK, 8'h55);
      push_request(KIND_TICK, 8'hAA);
      repeat (HISTORY_DEPTH + 8) push_request(KIND_TICK, 8'hFF);
      push_request(KIND_TICK, 8'h00);
      settle();

      // Each mask write re-enables every pin, so repeated edges grow the timeout
      // until the addition wraps to zero; the next quiet tick then wraps it down.
      for (int n = 0; n < 63; n++) begin
         write_register(MASK_ADDR, 32'hFF);
         push_request(KIND_EDGE, BTN_W'($urandom_range(1, 255)));
         settle();
      end
      write_register(MASK_ADDR, 32'hFF);
      repeat (HISTORY_DEPTH) push_request(KIND_TICK, 8'hFF);
      push_request(KIND_EDGE, BTN_W'($urandom_range(1, 255)));
      repeat (3) push_request(KIND_TICK, 8'hFF);
      settle();

      phase = 0;
      while (requests_queued < REQUEST_TARGET) begin
         case (phase)
            0: mask = 8'h01;
            1: mask = 8'hFF;
            2: mask = 8'h80;
            default: mask = BTN_W'($urandom_range(1, 255));
         endcase
         if (phase % 3 == 2) begin
            write_register(MASK_ADDR, '0);
            write_register(SPARE_ADDR, CSR_DATA_W'($urandom_range(1, 255)));
         end
         write_register(MASK_ADDR, CSR_DATA_W'(mask));
         idling_on = (requests_queued < REQUEST_TARGET - 100);
         repeat (4) begin
            if ($urandom_range(0, 9) < 7) begin
               queue_press(mask);
            end else begin
               repeat ($urandom_range(1, 4))
                  push_request(($urandom_range(0, 1) != 0) ? KIND_EDGE : KIND_TICK,
                               BTN_W'($urandom));
            end
         end
         // Hold the result side off long enough for the block to stall its input.
         if (phase == 1) rsp_hold_left = 150;
         settle();
         phase++;
      end

      if (expected_reports.size() != 0) begin
         $display("%0t: %0d expected reports never arrived", $time, expected_reports.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
